>>> rtl/hotp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotp_pkg
// Shared types and constants for the HOTP code generator.
// ----------------------------------------------------------------------------
package hotp_pkg;

   localparam int NUM_DIGITS = 6;

   localparam int CTR_W = 64;
   localparam int KEY_W = 64;
   localparam int OTP_W = 20;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_KEY_WORDS = 4;

   localparam int unsigned CODE_MOD = 10 ** NUM_DIGITS;
   localparam int REM_W = $clog2(CODE_MOD);
   localparam int TRUNC_W = 31;

   // remainder by reciprocal: 10^n = 2^n * 5^n, so drop n low bits and
   // multiply by a rounded-up reciprocal of 5^n for an exact quotient
   localparam int MOD_ODD = 5 ** NUM_DIGITS;
   localparam int MOD_ODD_W = $clog2(MOD_ODD);
   localparam int QV_W = TRUNC_W - NUM_DIGITS;
   localparam int RECIP_W = QV_W + 1;
   localparam int PROD_W = QV_W + RECIP_W;
   localparam int QUOT_W = RECIP_W - MOD_ODD_W;
   localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(
      ((64'd1 << (QV_W + MOD_ODD_W)) + 64'(MOD_ODD) - 64'd1) / 64'(MOD_ODD));

   localparam int BLOCK_W = 512;
   localparam int DIGEST_W = 160;
   localparam int ROUND_W = 7;
   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(79);

   localparam logic [DIGEST_W-1:0] SHA1_IV = {
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
   localparam logic [31:0] SHA1_K0 = 32'h5A827999;
   localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
   localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
   localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5C;
   // message lengths in bits: key block plus counter, key block plus digest
   localparam logic [63:0] INNER_LEN = 64'd576;
   localparam logic [63:0] OUTER_LEN = 64'd672;

   // key register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_3 = CSR_IDX_W'(3);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INNER1,
      ST_INNER2,
      ST_OUTER1,
      ST_OUTER2,
      ST_MOD
   } hotp_state_type;

   typedef struct packed {
      logic start;
      logic init;
   } sha_ctl_type;

endpackage

>>> rtl/hotp_sha1_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotp_sha1_core
// Round-serial SHA-1 compression: one round per cycle, with a load step before the rounds and a digest add after them.
// ----------------------------------------------------------------------------
module hotp_sha1_core (
   input  logic                          clock,
   input  logic                          reset,
   input  hotp_pkg::sha_ctl_type         ctl,
   input  logic [hotp_pkg::BLOCK_W-1:0]  block,
   output logic                          done,
   output logic [hotp_pkg::DIGEST_W-1:0] digest
);
   import hotp_pkg::*;

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [DIGEST_W-1:0] h_ff, h_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic run_ff, run_in, fin_ff, fin_in, done_ff, done_in;
   logic [31:0] f, k, t, w_new;
   logic [DIGEST_W-1:0] h_start;

   always_comb begin
      if (round_ff < ROUND_W'(20)) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = SHA1_K0;
      end else if (round_ff < ROUND_W'(40)) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = SHA1_K1;
      end else if (round_ff < ROUND_W'(60)) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = SHA1_K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = SHA1_K3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + w_ff[0];
      w_new = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   end

   assign h_start = ctl.init ? SHA1_IV : h_ff;

   always_comb begin
      w_in = w_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      h_in = h_ff;
      round_in = round_ff;
      run_in = run_ff;
      fin_in = 1'b0;
      done_in = 1'b0;
      if (ctl.start) begin
         for (int i = 0; i < 16; i++) begin
            w_in[i] = block[BLOCK_W-1-32*i -: 32];
         end
         h_in = h_start;
         a_in = h_start[159:128];
         b_in = h_start[127:96];
         c_in = h_start[95:64];
         d_in = h_start[63:32];
         e_in = h_start[31:0];
         round_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = {w_new[30:0], w_new[31]};
         e_in = d_ff;
         d_in = c_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         b_in = a_ff;
         a_in = t;
         round_in = round_ff + ROUND_W'(1);
         if (round_ff == LAST_ROUND) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         h_in = {h_ff[159:128] + a_ff, h_ff[127:96] + b_ff, h_ff[95:64] + c_ff,
                 h_ff[63:32] + d_ff, h_ff[31:0] + e_ff};
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      h_ff <= h_in;
      round_ff <= round_in;
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign digest = h_ff;

endmodule

>>> rtl/hotp_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotp_mod_unit
// Remainder of a 31-bit value by the code modulus: reciprocal multiply for
// the quotient, multiply back, subtract.
// ----------------------------------------------------------------------------
module hotp_mod_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hotp_pkg::TRUNC_W-1:0] value,
   output logic                         done,
   output logic [hotp_pkg::REM_W-1:0]   remainder
);
   import hotp_pkg::*;

   logic [TRUNC_W-1:0] val_ff, val_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [TRUNC_W-1:0] qmul_ff, qmul_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   // one-hot step: product, quotient times modulus, remainder
   logic [2:0] stage_ff, stage_in;
   logic done_ff, done_in;
   logic [QUOT_W-1:0] quot;

   assign quot = prod_ff[PROD_W-1 -: QUOT_W];

   always_comb begin
      val_in = val_ff;
      prod_in = prod_ff;
      qmul_in = qmul_ff;
      rem_in = rem_ff;
      stage_in = {stage_ff[1:0], start};
      done_in = stage_ff[2];
      if (start) begin
         val_in = value;
      end
      if (stage_ff[0]) begin
         prod_in = PROD_W'(val_ff[TRUNC_W-1 -: QV_W]) * PROD_W'(RECIP_K);
      end
      if (stage_ff[1]) begin
         qmul_in = TRUNC_W'(quot) * TRUNC_W'(CODE_MOD);
      end
      if (stage_ff[2]) begin
         rem_in = REM_W'(val_ff - qmul_ff);
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      prod_ff <= prod_in;
      qmul_ff <= qmul_in;
      rem_ff <= rem_in;
      if (reset) begin
         stage_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/hotp_code_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotp_code_generator
// HOTP one-time code: HMAC-SHA1 over a 64-bit counter, dynamic truncation,
// reduction modulo 10^NUM_DIGITS.
//
// Usage:
//   csr_*  : key write channel; csr_ready is always high. Index 0..3 selects
//            key word 0..3, other indexes are dropped. Write only while idle.
//   start  : a transaction is taken when start is high and busy is low;
//            req_moving_counter is captured then.
//   rsp_*  : rsp_valid pulses for one cycle with rsp_otp_code.
// A transaction runs 4 SHA-1 blocks (80 rounds each of the shared round
// unit plus load and digest add), then the reciprocal modulo unit and the
// output register. busy is high from the accepting edge until rsp_valid
// rises, so one transaction is in flight at a time; the next start may be
// taken at the edge that ends the rsp_valid cycle.
// Reset clears the key words to zero and returns the block to idle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module hotp_code_generator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hotp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hotp_pkg::KEY_W-1:0]     csr_wdata,
   input  logic                           start,
   output logic                           busy,
   input  logic [hotp_pkg::CTR_W-1:0]     req_moving_counter,
   output logic                           rsp_valid,
   output logic [hotp_pkg::OTP_W-1:0]     rsp_otp_code
);
   import hotp_pkg::*;

   hotp_state_type state_ff, state_in;
   logic [KEY_W-1:0] key_ff [NUM_KEY_WORDS];
   logic [CTR_W-1:0] ctr_ff;
   logic [DIGEST_W-1:0] ihash_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [OTP_W-1:0] rsp_otp_code_ff, rsp_otp_code_in;

   sha_ctl_type sha_ctl;
   logic [BLOCK_W-1:0] sha_block;
   logic sha_done;
   logic [DIGEST_W-1:0] sha_digest;
   logic mod_start, mod_done;
   logic [REM_W-1:0] mod_rem;
   logic [TRUNC_W-1:0] trunc_val;
   logic [DIGEST_W-1:0] digest_shifted;
   logic [255:0] key_bits;
   logic accept;

   assign csr_ready = 1'b1;
   assign accept = start && (state_ff == ST_IDLE);
   assign key_bits = {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_INNER1;
         ST_INNER1: if (sha_done) state_in = ST_INNER2;
         ST_INNER2: if (sha_done) state_in = ST_OUTER1;
         ST_OUTER1: if (sha_done) state_in = ST_OUTER2;
         ST_OUTER2: if (sha_done) state_in = ST_MOD;
         ST_MOD:    if (mod_done) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      sha_ctl = '0;
      sha_block = '0;
      mod_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            sha_ctl.start = start;
            sha_ctl.init = 1'b1;
            sha_block = {key_bits, 256'd0} ^ {64{IPAD}};
         end
         ST_INNER1: begin
            sha_ctl.start = sha_done;
            sha_block = {ctr_ff, 8'h80, 376'd0, INNER_LEN};
         end
         ST_INNER2: begin
            sha_ctl.start = sha_done;
            sha_ctl.init = 1'b1;
            sha_block = {key_bits, 256'd0} ^ {64{OPAD}};
         end
         ST_OUTER1: begin
            sha_ctl.start = sha_done;
            sha_block = {ihash_ff, 8'h80, 280'd0, OUTER_LEN};
         end
         ST_OUTER2: mod_start = sha_done;
         ST_MOD: ;
         default: ;
      endcase
   end

   // dynamic truncation: low nibble of the last byte picks the byte offset
   assign digest_shifted = sha_digest << {sha_digest[3:0], 3'b000};
   assign trunc_val = digest_shifted[DIGEST_W-2 -: TRUNC_W];

   assign rsp_valid_in = (state_ff == ST_MOD) && mod_done;
   assign rsp_otp_code_in = OTP_W'(mod_rem);

   always_ff @(posedge clock) begin
      if (accept) begin
         ctr_ff <= req_moving_counter;
      end
      if ((state_ff == ST_INNER2) && sha_done) begin
         ihash_ff <= sha_digest;
      end
      rsp_otp_code_ff <= rsp_otp_code_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_KEY_0: key_ff[0] <= csr_wdata;
               CSR_KEY_1: key_ff[1] <= csr_wdata;
               CSR_KEY_2: key_ff[2] <= csr_wdata;
               CSR_KEY_3: key_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   hotp_sha1_core u_sha1 (
      .clock  (clock),
      .reset  (reset),
      .ctl    (sha_ctl),
      .block  (sha_block),
      .done   (sha_done),
      .digest (sha_digest)
   );

   hotp_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .value     (trunc_val),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_otp_code = rsp_otp_code_ff;

endmodule

>>> rtl/hotp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hotp_checker
// Port-level checks for the HOTP code generator, bound to the top level.
// ----------------------------------------------------------------------------
module hotp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [hotp_pkg::OTP_W-1:0] rsp_otp_code
);
   import hotp_pkg::*;

   // an accepted transaction makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // a result strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held longer than one cycle");

   // a result only follows a transaction in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("rsp_valid without a transaction in flight");

   // no result right after an accept
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid)
      else $error("result too early after accept");

   // the code is below the modulus
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_otp_code) < CODE_MOD))
      else $error("code out of range");

endmodule

bind hotp_code_generator hotp_checker u_hotp_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_otp_code (rsp_otp_code)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HOTP code generator: a table of directed
// counters under several keys, then random counters and key changes, each
// result checked against an HMAC-SHA1 / dynamic truncation predictor.
// ----------------------------------------------------------------------------
module tb;
   import hotp_pkg::*;

   localparam int N_RANDOM = 1330;
   localparam int DRAIN_CYCLES = 500;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [KEY_W-1:0]     csr_wdata = '0;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CTR_W-1:0]     req_moving_counter = '0;
   logic                 rsp_valid;
   logic [OTP_W-1:0]     rsp_otp_code;

   logic [KEY_W-1:0]     key_shadow [NUM_KEY_WORDS];
   logic [OTP_W-1:0]     code_queue [$];
   int                   fail_count = 0;

   typedef struct {
      logic [CTR_W-1:0] counter;
      bit               known;
      logic [OTP_W-1:0] code;
   } ctr_row_type;

   hotp_code_generator uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #100ms;
      $display("tb NOT OK");
      $finish;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // one compression of a 512-bit block into the chaining value
   function automatic logic [DIGEST_W-1:0] compress(input logic [DIGEST_W-1:0] hv,
                                                    input logic [BLOCK_W-1:0] blk);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[BLOCK_W-1-32*i -: 32];
      for (int i = 16; i < 80; i++)
         w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      {a, b, c, d, e} = hv;
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d; k = 32'hCA62C1D6;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d,
              hv[31:0] + e};
   endfunction

   function automatic logic [OTP_W-1:0] hotp_code(input logic [CTR_W-1:0] ctr);
      logic [BLOCK_W-1:0]  kblk, blk;
      logic [DIGEST_W-1:0] hv, inner, dg;
      logic [31:0]         val;
      int                  off;
      kblk = {key_shadow[0], key_shadow[1], key_shadow[2], key_shadow[3], 256'd0};
      hv = compress(SHA1_IV, kblk ^ {64{8'h36}});
      blk = {ctr, 8'h80, 376'd0, 64'd576};
      inner = compress(hv, blk);
      hv = compress(SHA1_IV, kblk ^ {64{8'h5C}});
      blk = {inner, 8'h80, 280'd0, 64'd672};
      dg = compress(hv, blk);
      off = int'(dg[3:0]);
      val = dg[DIGEST_W-1-8*off -: 32];
      val[31] = 1'b0;
      return OTP_W'((val % 32'd1000000) & 32'hFFFFF);
   endfunction

   task automatic idle_cycles(input int n);
      repeat (n) @(negedge clock);
   endtask

   // bench is idle here; lets the last computation settle first
   task automatic write_key(input logic [CSR_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
      start <= 1'b0;
      wait (code_queue.size() == 0);
      @(negedge clock);
      while (busy) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_KEY_WORDS) key_shadow[idx] = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // with no gap, start stays high into the next transaction
   task automatic send_counter(input logic [CTR_W-1:0] ctr, input bit known,
                               input logic [OTP_W-1:0] code);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         req_moving_counter <= {$urandom, $urandom};
         idle_cycles(gap);
      end
      start <= 1'b1;
      req_moving_counter <= ctr;
      do @(posedge clock); while (busy);
      code_queue.push_back(known ? code : hotp_code(ctr));
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (code_queue.size() == 0) begin
            $error("unexpected transaction: otp_code %0d", rsp_otp_code);
            fail_count++;
         end else begin
            logic [OTP_W-1:0] want;
            want = code_queue.pop_front();
            if (rsp_otp_code !== want) begin
               $error("otp_code: expected %0d, got %0d", want, rsp_otp_code);
               fail_count++;
            end
         end
      end
   end

   task automatic random_key();
      for (int i = 0; i < NUM_KEY_WORDS; i++)
         write_key(CSR_IDX_W'(i), {$urandom, $urandom});
   endtask

   initial begin
      ctr_row_type rows [$];
      logic [CTR_W-1:0] ctr;
      for (int i = 0; i < NUM_KEY_WORDS; i++) key_shadow[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero key after reset, then all-ones, then an ASCII digit key
      rows = '{'{64'd0, 0, '0}, '{64'd1, 0, '0}, '{'1, 0, '0},
               '{64'h8000_0000_0000_0000, 0, '0}, '{64'h0123_4567_89AB_CDEF, 0, '0}};
      foreach (rows[i]) send_counter(rows[i].counter, rows[i].known, rows[i].code);
      write_key(CSR_KEY_0, '1); write_key(CSR_KEY_1, '1);
      write_key(CSR_KEY_2, '1); write_key(CSR_KEY_3, '1);
      foreach (rows[i]) send_counter(rows[i].counter, rows[i].known, rows[i].code);
      // out-of-range indexes must be dropped
      write_key(CSR_IDX_W'(4), 64'hDEAD_BEEF_0000_0001);
      write_key(CSR_IDX_W'(7), 64'h5555_AAAA_5555_AAAA);
      send_counter(64'd7, 0, '0);
      write_key(CSR_KEY_0, 64'h3132_3334_3536_3738);
      write_key(CSR_KEY_1, 64'h3930_3132_3334_3536);
      write_key(CSR_KEY_2, 64'h3738_3930_0000_0000);
      write_key(CSR_KEY_3, '0);
      for (int i = 0; i < 10; i++) send_counter(CTR_W'(i), 0, '0);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 200 == 0) random_key();
         case ($urandom_range(0, 3))
            0: ctr = CTR_W'($urandom_range(0, 100));
            1: ctr = '1 - CTR_W'($urandom_range(0, 100));
            default: ctr = {$urandom, $urandom};
         endcase
         send_counter(ctr, 0, '0);
      end
      start <= 1'b0;

      wait (code_queue.size() == 0);
      idle_cycles(DRAIN_CYCLES);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

>>> hotp_code_generator.f
rtl/hotp_pkg.sv
rtl/hotp_sha1_core.sv
rtl/hotp_mod_unit.sv
rtl/hotp_code_generator.sv
rtl/hotp_checker.sv
tb/sv/tb.sv
